// ===== rtl/charset_byte_decoder_assert.svh =====
// assertion macros for the charset byte decoder checks
`ifndef CHARSET_BYTE_DECODER_ASSERT_SVH
`define CHARSET_BYTE_DECODER_ASSERT_SVH

// same-cycle implication
`define CBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("charset byte decoder check failed");

// next-cycle implication
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("charset byte decoder check failed");

`endif

// ===== rtl/cbd_pkg.sv =====
// types, constants and the byte decode function of the charset byte decoder
package cbd_pkg;

   localparam logic [1:0] MODE_UTF8   = 2'd0;
   localparam logic [1:0] MODE_ASCII  = 2'd1;
   localparam logic [1:0] MODE_LATIN1 = 2'd2;

   localparam logic [7:0] QMARK = 8'h3F;

   // result of decoding one input byte against the held bytes
   typedef struct packed {
      logic [3:0][7:0] out_bytes;
      logic [2:0]      out_cnt;
      logic [2:0][7:0] pend_bytes;
      logic [1:0]      pend_cnt;
   } dec_result_type;

   // continuation bytes a lead byte takes, zero for a stray byte
   function automatic logic [1:0] cont_need(input logic [7:0] b);
      logic [1:0] need;
      need = 2'd0;
      if ((b & 8'hE0) == 8'hC0) begin
         need = 2'd1;
      end else if ((b & 8'hF0) == 8'hE0) begin
         need = 2'd2;
      end else if ((b & 8'hF8) == 8'hF0) begin
         need = 2'd3;
      end
      return need;
   endfunction

   // decode one byte; held bytes come first in the window
   function automatic dec_result_type cbd_decode(
      input logic [1:0]      mode,
      input logic [2:0][7:0] pend,
      input logic [1:0]      pcnt,
      input logic [7:0]      b,
      input logic            fin
   );
      dec_result_type  r;
      logic [6:0][7:0] ext;
      logic [2:0]      n;
      logic [2:0]      oc;
      logic [1:0]      skip;
      logic [1:0]      need;
      logic            done;
      r    = '0;
      ext  = '0;
      oc   = 3'd0;
      skip = 2'd0;
      need = 2'd0;
      done = 1'b0;
      for (int j = 0; j < 3; j++) begin
         ext[j] = pend[j];
      end
      ext[pcnt] = b;
      n = {1'b0, pcnt} + 3'd1;
      unique case (mode)
         MODE_ASCII: begin
            r.out_bytes[0] = b[7] ? QMARK : b;
            r.out_cnt      = 3'd1;
         end
         MODE_LATIN1: begin
            r.out_bytes[0] = b;
            r.out_cnt      = 3'd1;
         end
         default: begin
            // walk the window, one start position at a time
            for (int k = 0; k < 4; k++) begin
               if (!done && (3'(k) < n)) begin
                  if (skip != 2'd0) begin
                     skip = skip - 2'd1;
                  end else begin
                     need = cont_need(ext[k]);
                     if (!ext[k][7]) begin
                        r.out_bytes[oc[1:0]] = ext[k];
                        oc = oc + 3'd1;
                     end else if (need == 2'd0) begin
                        r.out_bytes[oc[1:0]] = QMARK;
                        oc = oc + 3'd1;
                     end else if ((3'(k) + {1'b0, need}) < n) begin
                        skip = need;
                        if (need == 2'd1) begin
                           // overlong when the code point is below 0x80
                           if (ext[k][4:1] == 4'd0) begin
                              r.out_bytes[oc[1:0]] = QMARK;
                              oc = oc + 3'd1;
                           end else begin
                              r.out_bytes[oc[1:0]] = {3'b110, ext[k][4:0]};
                              oc = oc + 3'd1;
                              r.out_bytes[oc[1:0]] = {2'b10, ext[k + 1][5:0]};
                              oc = oc + 3'd1;
                           end
                        end else begin
                           r.out_bytes[oc[1:0]] = ext[k];
                           oc = oc + 3'd1;
                           for (int j = 1; j < 4; j++) begin
                              if (2'(j) <= need) begin
                                 r.out_bytes[oc[1:0]] = {2'b10, ext[k + j][5:0]};
                                 oc = oc + 3'd1;
                              end
                           end
                        end
                     end else if (!fin) begin
                        // incomplete sequence: hold it for the next byte
                        for (int j = 0; j < 3; j++) begin
                           if ((3'(k) + 3'(j)) < n) begin
                              r.pend_bytes[j] = ext[k + j];
                           end
                        end
                        r.pend_cnt = 2'(n - 3'(k));
                        done       = 1'b1;
                     end else begin
                        r.out_bytes[oc[1:0]] = QMARK;
                        oc = oc + 3'd1;
                     end
                  end
               end
            end
            r.out_cnt = oc;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/cbd_req_if.sv =====
// input byte channel of the charset byte decoder
interface cbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_final;

   modport source (output valid, output in_byte, output is_final, input ready);
   modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

// ===== rtl/cbd_rsp_if.sv =====
// result byte channel of the charset byte decoder
interface cbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_last;

   modport source (output valid, output out_byte, output run_last, output stream_last,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input stream_last,
                 output ready);
endinterface

// ===== rtl/charset_byte_decoder.sv =====
// charset byte decoder top level: input stage, decode, result group serializer
// An accepted byte's beat is registered in the input stage, then its results in the result group register.
// Throughput: one input byte per cycle while each byte gives at most one result and rsp ready is high;
//   a byte that gives n results holds the result group register until all n results are sent.
// The result group register sets the rate: it sends one byte per cycle while rsp ready is high.
// Reset clears the mode to UTF-8, drops held bytes and empties both stages.
module charset_byte_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   cbd_req_if.sink     req_bus,
   cbd_rsp_if.source   rsp_bus
);
   import cbd_pkg::*;

   logic [1:0]      mode_ff;
   logic [1:0]      mode_in;
   logic            s1_valid_ff;
   logic            s1_valid_in;
   logic [7:0]      s1_byte_ff;
   logic            s1_final_ff;
   logic [2:0][7:0] pend_bytes_ff;
   logic [1:0]      pend_cnt_ff;
   logic [1:0]      pend_cnt_in;
   logic            grp_valid_ff;
   logic            grp_valid_in;
   logic [3:0][7:0] grp_bytes_ff;
   logic [2:0]      grp_cnt_ff;
   logic            grp_final_ff;
   logic [1:0]      grp_idx_ff;
   logic [1:0]      grp_idx_in;

   dec_result_type  dec;
   logic            grp_last;
   logic            grp_free;
   logic            s1_adv;
   logic            req_take;

   // decode of the staged byte against the held bytes
   assign dec = cbd_decode(mode_ff, pend_bytes_ff, pend_cnt_ff, s1_byte_ff, s1_final_ff);

   // handshake and stage advance
   assign grp_last       = (grp_idx_ff == 2'(grp_cnt_ff - 3'd1));
   assign grp_free       = !grp_valid_ff || (rsp_bus.ready && grp_last);
   assign s1_adv         = s1_valid_ff && grp_free;
   assign req_bus.ready  = !s1_valid_ff || grp_free;
   assign req_take       = req_bus.valid && req_bus.ready;

   // next state of control registers
   always_comb begin
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      s1_valid_in  = req_bus.ready ? req_bus.valid : s1_valid_ff;
      pend_cnt_in  = pend_cnt_ff;
      grp_valid_in = grp_valid_ff;
      grp_idx_in   = grp_idx_ff;
      if (csr_wr_en) begin
         pend_cnt_in = 2'd0;
      end else if (s1_adv) begin
         pend_cnt_in = dec.pend_cnt;
      end
      if (grp_free) begin
         grp_valid_in = s1_adv && (dec.out_cnt != 3'd0);
         grp_idx_in   = 2'd0;
      end else if (rsp_bus.ready) begin
         grp_idx_in = grp_idx_ff + 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UTF8;
         s1_valid_ff  <= 1'b0;
         pend_cnt_ff  <= 2'd0;
         grp_valid_ff <= 1'b0;
         grp_idx_ff   <= 2'd0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         pend_cnt_ff  <= pend_cnt_in;
         grp_valid_ff <= grp_valid_in;
         grp_idx_ff   <= grp_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_bus.in_byte;
         s1_final_ff <= req_bus.is_final;
      end
      if (s1_adv) begin
         pend_bytes_ff <= dec.pend_bytes;
         grp_bytes_ff  <= dec.out_bytes;
         grp_cnt_ff    <= dec.out_cnt;
         grp_final_ff  <= s1_final_ff;
      end
   end

   // result beat
   assign rsp_bus.valid       = grp_valid_ff;
   assign rsp_bus.out_byte    = grp_bytes_ff[grp_idx_ff];
   assign rsp_bus.run_last    = grp_last;
   assign rsp_bus.stream_last = grp_last && grp_final_ff;

endmodule

// ===== rtl/cbd_checker.sv =====
// port-level checks of the charset byte decoder and their bind
`include "charset_byte_decoder_assert.svh"

module cbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_stream_last
);

   // nothing is offered right after reset
   `CBD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // the end of the stream also ends the byte's group
   `CBD_ASSERT_SAME(a_stream_in_run, clock, reset,
                    rsp_valid && rsp_stream_last, rsp_run_last)

   // a group's beats follow one another without a gap
   `CBD_ASSERT_NEXT(a_group_runs_on, clock, reset,
                    rsp_valid && rsp_ready && !rsp_run_last, rsp_valid)

   // a stalled beat holds
   `CBD_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last))

endmodule

bind charset_byte_decoder cbd_checker u_cbd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_byte    (rsp_bus.out_byte),
   .rsp_run_last    (rsp_bus.run_last),
   .rsp_stream_last (rsp_bus.stream_last)
);
